[rtl/ggs_pkg.sv]
// ggs_pkg: shared types and constants of the go-to-goal steering block.
// Holds the request/result structs, the CORDIC datapath bus, the config set,
// the register index codes and the arctangent table. No dependencies.
package ggs_pkg;

    // CORDIC datapath widths (8 fraction bits on x, y and z)
    localparam int XY_W      = 27;
    localparam int Z_W       = 26;
    localparam int ATAN_W    = 22;
    localparam int CORDIC_MAX = 24;

    // 1/K in Q16, the converged CORDIC gain; not exact for small step counts
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    // quarter turn in binary angle units with 8 fraction bits
    localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(16384 * 256);

    // arctangent of 2^-i, binary angle units with 8 fraction bits
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:CORDIC_MAX-1] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669,  22'd83416,   22'd41718,  22'd20860,
        22'd10430,   22'd5215,    22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81,
        22'd41,      22'd20,      22'd10,     22'd5,
        22'd3,       22'd1,       22'd1,      22'd0
    };

    // config register indexes
    typedef enum logic [2:0] {
        CFG_ARRIVE_DISTANCE  = 3'd0,
        CFG_TURN_FIRST_ANGLE = 3'd1,
        CFG_HEADING_GAIN     = 3'd2,
        CFG_DISTANCE_GAIN    = 3'd3,
        CFG_ANGULAR_LIMIT    = 3'd4,
        CFG_LINEAR_LIMIT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } t_ggs_req;

    typedef struct packed {
        logic               arrived;
        logic signed [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
    } t_ggs_res;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic_bus;

    typedef struct packed {
        logic [15:0] arrive_distance;
        logic [14:0] turn_first_angle;
        logic [15:0] heading_gain;
        logic [15:0] distance_gain;
        logic [14:0] angular_limit;
        logic [14:0] linear_limit;
    } t_ggs_cfg;

endpackage

[rtl/go_to_goal_steering.sv]
// go_to_goal_steering: top level; config registers, quadrant pre-rotation,
// the CORDIC stage chain and the post-processing back end.
// Depends on ggs_pkg, ggs_cordic_stage and ggs_post.
//
// Usage: a request carries a target (x forward, y left, mm) on i_req with
// i_req_valid; it is taken on a clock edge where i_req_valid is high and
// o_req_stall is low. Each request yields one result on o_res/o_res_valid:
// arrived flag, linear and angular commands, taken when i_res_stall is low.
// The path has one pre-rotation stage, one stage per CORDIC iteration and
// four back-end stages. While no stall holds the chain, a new request can
// enter every cycle; throughput is one result per cycle, set by the pipelined
// iteration chain. Each stage holds its item while the one ahead is full, so
// a receiver stall fills the bubbles first and then backs up to o_req_stall;
// nothing is dropped or repeated. Config writes (i_cfg_we, i_cfg_addr,
// i_cfg_data) take effect at once and belong in idle periods; indexes past
// the last register are ignored. Synchronous reset empties the pipeline and
// loads the default register values.
module go_to_goal_steering #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  ggs_pkg::t_ggs_req i_req,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output ggs_pkg::t_ggs_res o_res
);
    import ggs_pkg::*;

    t_ggs_cfg    r_cfg;
    logic        r_pre_valid;
    t_cordic_bus r_pre_bus;
    t_cordic_bus n_pre_bus;
    logic        pre_ready;
    logic signed [16:0] nx;
    logic signed [16:0] ny;

    logic        c_valid [0:CORDIC_STEPS];
    logic        c_ready [0:CORDIC_STEPS];
    t_cordic_bus c_bus   [0:CORDIC_STEPS];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arrive_distance  <= 16'd50;
            r_cfg.turn_first_angle <= 15'd5461;
            r_cfg.heading_gain     <= 16'd512;
            r_cfg.distance_gain    <= 16'd256;
            r_cfg.angular_limit    <= 15'd16384;
            r_cfg.linear_limit     <= 15'd500;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_ARRIVE_DISTANCE:  r_cfg.arrive_distance  <= i_cfg_data;
                CFG_TURN_FIRST_ANGLE: r_cfg.turn_first_angle <= i_cfg_data[14:0];
                CFG_HEADING_GAIN:     r_cfg.heading_gain     <= i_cfg_data;
                CFG_DISTANCE_GAIN:    r_cfg.distance_gain    <= i_cfg_data;
                CFG_ANGULAR_LIMIT:    r_cfg.angular_limit    <= i_cfg_data[14:0];
                CFG_LINEAR_LIMIT:     r_cfg.linear_limit     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pre-rotation: move targets behind the robot into the right half-plane
    always_comb begin
        nx = 17'(i_req.target_x);
        ny = 17'(i_req.target_y);
        n_pre_bus.z = '0;
        if (i_req.target_x[15]) begin
            if (!i_req.target_y[15]) begin
                nx          = 17'(i_req.target_y);
                ny          = -17'(i_req.target_x);
                n_pre_bus.z = QUARTER_TURN;
            end else begin
                nx          = -17'(i_req.target_y);
                ny          = 17'(i_req.target_x);
                n_pre_bus.z = -QUARTER_TURN;
            end
        end
        n_pre_bus.x = XY_W'(nx) <<< 8;
        n_pre_bus.y = XY_W'(ny) <<< 8;
    end

    assign pre_ready   = !r_pre_valid || c_ready[0];
    assign o_req_stall = !pre_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (pre_ready) begin
            r_pre_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_ready && i_req_valid) begin
            r_pre_bus <= n_pre_bus;
        end
    end

    assign c_valid[0] = r_pre_valid;
    assign c_bus[0]   = r_pre_bus;

    // CORDIC iteration chain, one registered stage per step
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        ggs_cordic_stage #(
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_bus   (c_bus[k]),
            .o_ready (c_ready[k]),
            .o_valid (c_valid[k+1]),
            .o_bus   (c_bus[k+1]),
            .i_ready (c_ready[k+1])
        );
    end

    // back end: distance, heading, commands
    ggs_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (c_valid[CORDIC_STEPS]),
        .i_bus       (c_bus[CORDIC_STEPS]),
        .o_ready     (c_ready[CORDIC_STEPS]),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

[rtl/ggs_cordic_stage.sv]
// ggs_cordic_stage: one registered CORDIC vectoring iteration.
// Depends on ggs_pkg (t_cordic_bus, ATAN_TAB).
module ggs_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ggs_pkg::t_cordic_bus i_bus,
    output logic                 o_ready,
    output logic                 o_valid,
    output ggs_pkg::t_cordic_bus o_bus,
    input  logic                 i_ready
);
    import ggs_pkg::*;

    logic                   r_valid;
    t_cordic_bus            r_bus;
    t_cordic_bus            n_bus;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  atan_z;

    // stage empties or hands on its item
    assign o_ready = !r_valid || i_ready;

    // rotate toward the x axis by atan(2^-STAGE)
    always_comb begin
        xs     = i_bus.x >>> STAGE;
        ys     = i_bus.y >>> STAGE;
        atan_z = signed'(Z_W'(ATAN_TAB[STAGE]));
        if (!i_bus.y[XY_W-1]) begin
            n_bus.x = i_bus.x + ys;
            n_bus.y = i_bus.y - xs;
            n_bus.z = i_bus.z + atan_z;
        end else begin
            n_bus.x = i_bus.x - ys;
            n_bus.y = i_bus.y + xs;
            n_bus.z = i_bus.z - atan_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

[rtl/ggs_post.sv]
// ggs_post: four-stage back end: gain removal, heading rounding, arrive and
// turn checks, command gains, saturation and the result register.
// Depends on ggs_pkg (t_cordic_bus, t_ggs_cfg, t_ggs_res).
module ggs_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ggs_pkg::t_ggs_cfg    i_cfg,
    input  logic                 i_valid,
    input  ggs_pkg::t_cordic_bus i_bus,
    output logic                 o_ready,
    output logic                 o_res_valid,
    output ggs_pkg::t_ggs_res    o_res,
    input  logic                 i_res_stall
);
    import ggs_pkg::*;

    // stage valids and ready chain
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: distance product, rounded heading
    logic [41:0]        r_prod;
    logic signed [15:0] r_head1;
    logic [41:0]        n_prod;
    logic signed [15:0] n_head1;
    logic signed [Z_W:0] z_rnd;
    logic signed [18:0] h_wide;

    // stage 2: distance, flags
    logic [16:0]        r_dist;
    logic signed [15:0] r_head2;
    logic               r_arr2;
    logic               r_turn2;
    logic [42:0]        d_sum;
    logic [16:0]        n_dist;
    logic [16:0]        h_abs;

    // stage 3: gain products
    logic signed [32:0] r_ang_prod;
    logic [32:0]        r_lin_prod;
    logic               r_arr3;
    logic               r_turn3;
    logic signed [16:0] hg_s;
    logic signed [32:0] n_ang_prod;
    logic [32:0]        n_lin_prod;

    // stage 4: saturated commands
    t_ggs_res           r_res;
    t_ggs_res           n_res;
    logic signed [24:0] ang_sh;
    logic signed [24:0] ang_lim;
    logic signed [24:0] ang_sat;
    logic [24:0]        lin_sh;
    logic [24:0]        lin_sat;

    assign rdy4    = !r_v4 || !i_res_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: x is never negative after vectoring
    always_comb begin
        n_prod = 42'(i_bus.x[XY_W-2:0]) * 42'(INV_GAIN_Q16);
        z_rnd  = (Z_W+1)'(i_bus.z) + (Z_W+1)'(128);
        h_wide = 19'(z_rnd >>> 8);
        if (h_wide > 19'sd32767) begin
            n_head1 = 16'sd32767;
        end else if (h_wide < -19'sd32768) begin
            n_head1 = -16'sd32768;
        end else begin
            n_head1 = h_wide[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_prod  <= n_prod;
            r_head1 <= n_head1;
        end
    end

    // stage 2: round distance, arrive and turn-in-place checks
    always_comb begin
        d_sum  = 43'(r_prod) + 43'(1 << 23);
        n_dist = d_sum[40:24];
        h_abs  = r_head1[15] ? 17'(-17'(r_head1)) : 17'(r_head1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_dist  <= n_dist;
            r_head2 <= r_head1;
            r_arr2  <= n_dist < 17'(i_cfg.arrive_distance);
            r_turn2 <= h_abs > 17'(i_cfg.turn_first_angle);
        end
    end

    // stage 3: proportional gains
    always_comb begin
        hg_s       = signed'({1'b0, i_cfg.heading_gain});
        n_ang_prod = hg_s * r_head2;
        n_lin_prod = 33'(i_cfg.distance_gain) * 33'(r_dist);
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_ang_prod <= n_ang_prod;
            r_lin_prod <= n_lin_prod;
            r_arr3     <= r_arr2;
            r_turn3    <= r_turn2;
        end
    end

    // stage 4: floor shift, symmetric saturation, zeroing
    always_comb begin
        ang_sh  = r_ang_prod[32:8];
        ang_lim = signed'(25'(i_cfg.angular_limit));
        if (ang_sh > ang_lim) begin
            ang_sat = ang_lim;
        end else if (ang_sh < -ang_lim) begin
            ang_sat = -ang_lim;
        end else begin
            ang_sat = ang_sh;
        end
        lin_sh  = r_lin_prod[32:8];
        lin_sat = (lin_sh > 25'(i_cfg.linear_limit)) ? 25'(i_cfg.linear_limit) : lin_sh;

        n_res.arrived     = r_arr3;
        n_res.angular_cmd = r_arr3 ? 16'sd0 : ang_sat[15:0];
        n_res.linear_cmd  = (r_arr3 || r_turn3) ? 16'sd0 : signed'(lin_sat[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_v4;
    assign o_res       = r_res;

endmodule
